// ===== rtl/stam_pkg.sv =====
package stam_pkg;

   localparam int TIME_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int FLAG_WIDTH      = 4;
   localparam int ALARM_WIDTH     = 5;
   localparam int PCT_WIDTH       = 7;
   localparam int BYTE_WIDTH      = 8;
   localparam int WORD_WIDTH      = 16;
   localparam int DUST_LIM_WIDTH  = 10;
   localparam int LIGHT_LIM_WIDTH = 14;
   localparam int TEMP_LIM_WIDTH  = 6;

   localparam logic [DUST_LIM_WIDTH-1:0]  DUST_LIMIT_MAX  = 10'd999;
   localparam logic [PCT_WIDTH-1:0]       PCT_MAX         = 7'd100;
   localparam logic [LIGHT_LIM_WIDTH-1:0] LIGHT_LIMIT_MAX = 14'd9999;
   localparam logic [TEMP_LIM_WIDTH-1:0]  TEMP_LIMIT_MAX  = 6'd50;
   localparam logic [WORD_WIDTH-1:0]      TIMING_MIN      = 16'd1;

   localparam logic [DUST_LIM_WIDTH-1:0]  DUST_LIMIT_RESET  = 10'd75;
   localparam logic [PCT_WIDTH-1:0]       GAS_LIMIT_RESET   = 7'd60;
   localparam logic [LIGHT_LIM_WIDTH-1:0] LIGHT_LIMIT_RESET = 14'd1000;
   localparam logic [TEMP_LIM_WIDTH-1:0]  TEMP_LIMIT_RESET  = 6'd30;
   localparam logic [PCT_WIDTH-1:0]       HUM_LIMIT_RESET   = 7'd80;
   localparam logic [WORD_WIDTH-1:0]      TIMEOUT_RESET     = 16'd3000;
   localparam logic [WORD_WIDTH-1:0]      INTERVAL_RESET    = 16'd1000;

   // gas percent = floor((mv + 25) / 50), capped at 100 from 5025 mV up
   localparam int GAS_SUM_WIDTH  = 13;
   localparam int GAS_PROD_WIDTH = 25;
   localparam int GAS_SHIFT      = 18;
   localparam logic [WORD_WIDTH-1:0]    GAS_CAP_MV = 16'd5025;
   localparam logic [GAS_SUM_WIDTH-1:0] GAS_ROUND  = 13'd25;
   localparam logic [GAS_SUM_WIDTH-1:0] GAS_RECIP  = 13'd5243;

   localparam int FLAG_TEMP_HUM = 0;
   localparam int FLAG_DUST     = 1;
   localparam int FLAG_GAS      = 2;
   localparam int FLAG_LIGHT    = 3;

   localparam int ALARM_DUST  = 0;
   localparam int ALARM_GAS   = 1;
   localparam int ALARM_LIGHT = 2;
   localparam int ALARM_TEMP  = 3;
   localparam int ALARM_HUM   = 4;

   localparam logic ACTION_TICK   = 1'b0;
   localparam logic ACTION_REPORT = 1'b1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DUST_LIMIT     = 3'd0,
      CSR_GAS_LIMIT      = 3'd1,
      CSR_LIGHT_LIMIT    = 3'd2,
      CSR_TEMP_LIMIT     = 3'd3,
      CSR_HUM_LIMIT      = 3'd4,
      CSR_LINK_TIMEOUT   = 3'd5,
      CSR_QUERY_INTERVAL = 3'd6
   } stam_csr_index_type;

   typedef struct packed {
      logic [DUST_LIM_WIDTH-1:0]  dust_limit;
      logic [PCT_WIDTH-1:0]       gas_percent_limit;
      logic [LIGHT_LIM_WIDTH-1:0] light_limit;
      logic [TEMP_LIM_WIDTH-1:0]  temperature_limit;
      logic [PCT_WIDTH-1:0]       humidity_limit;
      logic [WORD_WIDTH-1:0]      link_timeout;
      logic [WORD_WIDTH-1:0]      query_interval;
   } stam_cfg_type;

   typedef struct packed {
      logic                   report_seen;
      logic                   stale;
      logic                   query;
      logic [FLAG_WIDTH-1:0]  valid_flags;
      logic [BYTE_WIDTH-1:0]  temperature;
      logic [BYTE_WIDTH-1:0]  humidity;
      logic [WORD_WIDTH-1:0]  dust_level;
      logic [PCT_WIDTH-1:0]   gas_pct;
      logic [WORD_WIDTH-1:0]  light_level;
   } stam_snap_type;

endpackage

// ===== rtl/stam_if.sv =====
interface stam_req_if;
   import stam_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [FLAG_WIDTH-1:0] valid_flags;
   logic [BYTE_WIDTH-1:0] temperature;
   logic [BYTE_WIDTH-1:0] humidity;
   logic [WORD_WIDTH-1:0] dust_level;
   logic [WORD_WIDTH-1:0] gas_millivolts;
   logic [WORD_WIDTH-1:0] light_level;

   modport source (
      output valid, action, valid_flags, temperature, humidity,
             dust_level, gas_millivolts, light_level,
      input  ready
   );

   modport sink (
      input  valid, action, valid_flags, temperature, humidity,
             dust_level, gas_millivolts, light_level,
      output ready
   );
endinterface

interface stam_rsp_if;
   import stam_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ALARM_WIDTH-1:0] alarm_bits;
   logic                   link_stale;
   logic                   send_query;
   logic                   alarm_rising;
   logic                   buzzer_active;
   logic [PCT_WIDTH-1:0]   gas_pct;

   modport source (
      output valid, alarm_bits, link_stale, send_query, alarm_rising,
             buzzer_active, gas_pct,
      input  ready
   );

   modport sink (
      input  valid, alarm_bits, link_stale, send_query, alarm_rising,
             buzzer_active, gas_pct,
      output ready
   );
endinterface

// ===== rtl/sensor_threshold_alarm_monitor_core.sv =====
// An accepted request is registered in the time/link stage, then in the alarm stage, which drives the result.
// Throughput: one request per cycle while the result is not stalled (rsp.ready high or no result held).
// A stalled result holds the alarm stage, and the link stage then holds one request more.
// Reset clears time, link and cached readings, and loads the threshold and timing reset values.
// No clearing pass: requests are accepted as soon as reset is released.
module sensor_threshold_alarm_monitor_core (
   input  logic                                 clock,
   input  logic                                 reset,
   stam_req_if.sink                             req,
   stam_rsp_if.source                           rsp,
   input  logic                                 csr_write_enable,
   input  logic [stam_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [stam_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import stam_pkg::*;

   stam_cfg_type  cfg;
   stam_snap_type snap;
   logic          snap_valid;
   logic          advance;

   stam_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   stam_link u_link (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg),
      .advance    (advance),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   stam_alarm u_alarm (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .snap_valid (snap_valid),
      .snap       (snap),
      .advance    (advance),
      .rsp        (rsp)
   );

endmodule

// ===== rtl/stam_csr.sv =====
module stam_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [stam_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [stam_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   output stam_pkg::stam_cfg_type                 cfg
);
   import stam_pkg::*;

   stam_cfg_type cfg_ff;
   stam_cfg_type cfg_in;

   logic [DUST_LIM_WIDTH-1:0]  dust_value;
   logic [PCT_WIDTH-1:0]       pct_value;
   logic [LIGHT_LIM_WIDTH-1:0] light_value;
   logic [TEMP_LIM_WIDTH-1:0]  temp_value;
   logic [WORD_WIDTH-1:0]      word_value;

   always_comb begin
      dust_value  = csr_write_data[DUST_LIM_WIDTH-1:0];
      pct_value   = csr_write_data[PCT_WIDTH-1:0];
      light_value = csr_write_data[LIGHT_LIM_WIDTH-1:0];
      temp_value  = csr_write_data[TEMP_LIM_WIDTH-1:0];
      word_value  = csr_write_data[WORD_WIDTH-1:0];

      if (dust_value > DUST_LIMIT_MAX) dust_value = DUST_LIMIT_MAX;
      if (pct_value > PCT_MAX) pct_value = PCT_MAX;
      if (light_value > LIGHT_LIMIT_MAX) light_value = LIGHT_LIMIT_MAX;
      if (temp_value > TEMP_LIMIT_MAX) temp_value = TEMP_LIMIT_MAX;
      if (word_value < TIMING_MIN) word_value = TIMING_MIN;

      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DUST_LIMIT:     cfg_in.dust_limit        = dust_value;
            CSR_GAS_LIMIT:      cfg_in.gas_percent_limit = pct_value;
            CSR_LIGHT_LIMIT:    cfg_in.light_limit       = light_value;
            CSR_TEMP_LIMIT:     cfg_in.temperature_limit = temp_value;
            CSR_HUM_LIMIT:      cfg_in.humidity_limit    = pct_value;
            CSR_LINK_TIMEOUT:   cfg_in.link_timeout      = word_value;
            CSR_QUERY_INTERVAL: cfg_in.query_interval    = word_value;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dust_limit        <= DUST_LIMIT_RESET;
         cfg_ff.gas_percent_limit <= GAS_LIMIT_RESET;
         cfg_ff.light_limit       <= LIGHT_LIMIT_RESET;
         cfg_ff.temperature_limit <= TEMP_LIMIT_RESET;
         cfg_ff.humidity_limit    <= HUM_LIMIT_RESET;
         cfg_ff.link_timeout      <= TIMEOUT_RESET;
         cfg_ff.query_interval    <= INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/stam_link.sv =====
module stam_link (
   input  logic                    clock,
   input  logic                    reset,
   stam_req_if.sink                req,
   input  stam_pkg::stam_cfg_type  cfg,
   input  logic                    advance,
   output logic                    snap_valid,
   output stam_pkg::stam_snap_type snap
);
   import stam_pkg::*;

   logic [TIME_WIDTH-1:0] time_ff, time_in;
   logic [TIME_WIDTH-1:0] time_next_ff, time_next_in;
   logic [TIME_WIDTH-1:0] last_report_ff, last_report_in;
   logic [TIME_WIDTH-1:0] last_query_ff, last_query_in;
   logic                  valid_ff, valid_in;
   stam_snap_type         snap_ff, snap_in;

   logic                     accept;
   logic [TIME_WIDTH-1:0]    report_age;
   logic [TIME_WIDTH-1:0]    query_age;
   logic [TIME_WIDTH-1:0]    timeout_ext;
   logic [TIME_WIDTH-1:0]    interval_ext;
   logic [GAS_SUM_WIDTH-1:0] gas_sum;
   logic [GAS_PROD_WIDTH-1:0] gas_prod;
   logic [PCT_WIDTH-1:0]     gas_pct;

   assign req.ready = !valid_ff || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      gas_sum  = req.gas_millivolts[GAS_SUM_WIDTH-1:0] + GAS_ROUND;
      gas_prod = GAS_PROD_WIDTH'(gas_sum) * GAS_PROD_WIDTH'(GAS_RECIP);
      if (req.gas_millivolts >= GAS_CAP_MV) begin
         gas_pct = PCT_MAX;
      end else begin
         gas_pct = gas_prod[GAS_SHIFT +: PCT_WIDTH];
      end
   end

   always_comb begin
      timeout_ext  = TIME_WIDTH'(cfg.link_timeout);
      interval_ext = TIME_WIDTH'(cfg.query_interval);
      report_age   = time_next_ff - last_report_ff;
      query_age    = time_next_ff - last_query_ff;

      time_in        = time_ff;
      time_next_in   = time_next_ff;
      last_report_in = last_report_ff;
      last_query_in  = last_query_ff;
      snap_in        = snap_ff;
      valid_in       = valid_ff && !advance;

      if (accept) begin
         valid_in = 1'b1;
         if (req.action == ACTION_REPORT) begin
            snap_in.valid_flags = req.valid_flags;
            snap_in.temperature = req.temperature;
            snap_in.humidity    = req.humidity;
            snap_in.dust_level  = req.dust_level;
            snap_in.gas_pct     = gas_pct;
            snap_in.light_level = req.light_level;
            snap_in.report_seen = 1'b1;
            snap_in.stale       = 1'b0;
            snap_in.query       = 1'b0;
            last_report_in      = time_ff;
         end else begin
            time_in       = time_next_ff;
            time_next_in  = time_next_ff + TIME_WIDTH'(1);
            snap_in.stale = !snap_ff.report_seen || (report_age > timeout_ext);
            snap_in.query = snap_in.stale && (query_age >= interval_ext);
            if (snap_in.query) last_query_in = time_next_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff        <= '0;
         time_next_ff   <= TIME_WIDTH'(1);
         last_report_ff <= '0;
         last_query_ff  <= '0;
         valid_ff       <= 1'b0;
         snap_ff        <= '0;
      end else begin
         time_ff        <= time_in;
         time_next_ff   <= time_next_in;
         last_report_ff <= last_report_in;
         last_query_ff  <= last_query_in;
         valid_ff       <= valid_in;
         snap_ff        <= snap_in;
      end
   end

   assign snap_valid = valid_ff;
   assign snap       = snap_ff;

endmodule

// ===== rtl/stam_alarm.sv =====
module stam_alarm (
   input  logic                    clock,
   input  logic                    reset,
   input  stam_pkg::stam_cfg_type  cfg,
   input  logic                    snap_valid,
   input  stam_pkg::stam_snap_type snap,
   output logic                    advance,
   stam_rsp_if.source              rsp
);
   import stam_pkg::*;

   logic                   out_valid_ff, out_valid_in;
   logic [ALARM_WIDTH-1:0] prev_alarms_ff, prev_alarms_in;
   logic [ALARM_WIDTH-1:0] alarm_bits_ff, alarm_bits_in;
   logic                   stale_ff, stale_in;
   logic                   query_ff, query_in;
   logic                   rising_ff, rising_in;
   logic                   buzzer_ff, buzzer_in;
   logic [PCT_WIDTH-1:0]   pct_ff, pct_in;

   logic fresh;

   assign advance = snap_valid && (!out_valid_ff || rsp.ready);

   always_comb begin
      fresh         = snap.report_seen && !snap.stale;
      alarm_bits_in = '0;
      pct_in        = '0;
      if (fresh) begin
         alarm_bits_in[ALARM_DUST] = snap.valid_flags[FLAG_DUST] &&
            (snap.dust_level > WORD_WIDTH'(cfg.dust_limit));
         alarm_bits_in[ALARM_GAS] = snap.valid_flags[FLAG_GAS] &&
            (snap.gas_pct > cfg.gas_percent_limit);
         alarm_bits_in[ALARM_LIGHT] = snap.valid_flags[FLAG_LIGHT] &&
            (snap.light_level > WORD_WIDTH'(cfg.light_limit));
         alarm_bits_in[ALARM_TEMP] = snap.valid_flags[FLAG_TEMP_HUM] &&
            (snap.temperature > BYTE_WIDTH'(cfg.temperature_limit));
         alarm_bits_in[ALARM_HUM] = snap.valid_flags[FLAG_TEMP_HUM] &&
            (snap.humidity > BYTE_WIDTH'(cfg.humidity_limit));
         if (snap.valid_flags[FLAG_GAS]) pct_in = snap.gas_pct;
      end
      stale_in  = snap.stale;
      query_in  = snap.query;
      buzzer_in = |alarm_bits_in;
      rising_in = buzzer_in && (prev_alarms_ff == '0);

      prev_alarms_in = advance ? alarm_bits_in : prev_alarms_ff;
      out_valid_in   = advance || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         prev_alarms_ff <= '0;
      end else begin
         out_valid_ff   <= out_valid_in;
         prev_alarms_ff <= prev_alarms_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         alarm_bits_ff <= alarm_bits_in;
         stale_ff      <= stale_in;
         query_ff      <= query_in;
         rising_ff     <= rising_in;
         buzzer_ff     <= buzzer_in;
         pct_ff        <= pct_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.alarm_bits    = alarm_bits_ff;
   assign rsp.link_stale    = stale_ff;
   assign rsp.send_query    = query_ff;
   assign rsp.alarm_rising  = rising_ff;
   assign rsp.buzzer_active = buzzer_ff;
   assign rsp.gas_pct       = pct_ff;

   a_buzzer_follows_bits: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.buzzer_active == (rsp.alarm_bits != '0)))
      else $error("buzzer does not follow alarm bits");

   a_stale_no_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.link_stale) |-> (rsp.alarm_bits == '0 && rsp.gas_pct == '0))
      else $error("alarm or gas percent on stale link");

   a_query_when_stale: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.send_query) |-> rsp.link_stale)
      else $error("query requested on fresh link");

   a_pct_capped: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.gas_pct <= PCT_MAX))
      else $error("gas percent above cap");

   a_rising_after_quiet: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rising_ff == (buzzer_ff && ($past(prev_alarms_ff) == '0))))
      else $error("rising edge flag mismatch");

endmodule
